// File: rtl/i8dp_pkg.sv
// ============================================================================
// i8dp_pkg: shared definitions for the int4 x int8 block dot product
// Field widths, arithmetic widths, multiplier operand codes and the control
// bundle passed from the sequencer to the datapath.
// ============================================================================
package i8dp_pkg;

    // Block and arithmetic configuration.
    localparam int BLK_BYTES  = 32;
    localparam int SCALE_FRAC = 12;
    localparam int ACC_WIDTH  = 56;
    localparam int RES_FRAC   = 24;
    localparam int OUT_WIDTH  = 48;

    // Fixed field widths.
    localparam int WB_W    = 8;
    localparam int ACT_W   = 8;
    localparam int SCALE_W = 16;
    localparam int BIAS_W  = 32;
    localparam int BSUM_W  = 17;
    localparam int NIB_W   = 4;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 48;

    localparam int POS_W = (BLK_BYTES > 1) ? $clog2(BLK_BYTES) : 1;

    // Shared multiplier: a signed (weight nibble, block sum or zero-extended scale),
    // b signed (activation, zero-extended scale or zero-extended scale product).
    localparam int SPROD_W = 2 * SCALE_W;
    localparam int MUL_A_W = (BSUM_W > SCALE_W + 1) ? BSUM_W : SCALE_W + 1;
    localparam int MUL_B_W = SPROD_W + 1;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;

    // Alignment of the scaled block sum to RES_FRAC fraction bits.
    localparam int ALIGN_SH = RES_FRAC - 2 * SCALE_FRAC;
    localparam int ALIGN_L  = (ALIGN_SH > 0) ? ALIGN_SH : 0;
    localparam int ALIGN_R  = (ALIGN_SH < 0) ? -ALIGN_SH : 0;
    localparam int SCL_W    = MUL_W + ALIGN_L + 1;
    localparam int ADD_W    = ((SCL_W > ACC_WIDTH) ? SCL_W : ACC_WIDTH) + 1;
    localparam int TOT_W    = ((ACC_WIDTH > BIAS_W) ? ACC_WIDTH : BIAS_W) + 1;

    // Multiplier operand selections.
    localparam int MSEL_W = 3;
    localparam logic [MSEL_W-1:0] MSEL_BYTE0 = 3'd0;  // low nibble x act_low
    localparam logic [MSEL_W-1:0] MSEL_BYTE1 = 3'd1;  // high nibble x act_high
    localparam logic [MSEL_W-1:0] MSEL_SCL0  = 3'd2;  // wscale_first x ascale_first
    localparam logic [MSEL_W-1:0] MSEL_SCL1  = 3'd3;  // wscale_second x ascale_second
    localparam logic [MSEL_W-1:0] MSEL_SUM0  = 3'd4;  // first sum x scale product
    localparam logic [MSEL_W-1:0] MSEL_SUM1  = 3'd5;  // second sum x scale product

    typedef struct packed {
        logic [MSEL_W-1:0] mul_sel;
        logic              mul_en;
        logic              sum0_add;
        logic              sum1_add;
        logic              pos_step;
        logic              acc_add;
        logic              blk_done;
        logic              row_done;
        logic              in_ready;
    } i8dp_ctrl_t;

endpackage

// File: rtl/int4_int8_block_dot_product.sv
// ============================================================================
// int4_int8_block_dot_product: int4 x int8 block-quantized row dot product
// Accumulates two interleaved blocks of nibble-by-int8 products, scales each
// finished block by its weight and activation scales into a saturating row
// accumulator, and emits the optionally biased, saturated row sum on the row end.
// ============================================================================
//
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tdata (weights, acts, scales,
//                                            bias), s_tlast (row_end)
// m_*       out        m_tvalid / m_tready   m_tdata (dot_result),
//                                            m_tuser (saturated)
// cfg_*     in         cfg_valid / cfg_ready cfg_data (use_bias)
//
// After its accept step, an ordinary byte takes one multiply per nibble
// through the single shared multiplier and a step to fold in the second
// product before s_tready rises again. The byte that closes a block adds
// the two block scalings, each a scale product followed by a
// sum-times-scale product on the same multiplier. A row end adds a final
// step, and stalls there while the previous result still sits in the
// output register. Reset is synchronous and active low; it clears the
// sequencer, the counters, the sums, the accumulator and use_bias.
// Configuration writes are always taken.
// ============================================================================
module int4_int8_block_dot_product (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Fields from bit 0 up: weight_byte[7:0], act_low[15:8], act_high[23:16],
    // wscale_first[39:24], wscale_second[55:40], ascale_first[71:56],
    // ascale_second[87:72], bias_value[119:88].
    input  logic [i8dp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,   // row_end
    input  logic                                 s_tvalid,
    output logic                                 s_tready,

    // Fields from bit 0 up: dot_result[47:0].
    output logic [i8dp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Fields from bit 0 up: saturated[0].
    output logic [0:0]                           m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,

    input  logic [0:0]                           cfg_data,  // use_bias
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready
);
    import i8dp_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    i8dp_ctrl_t ctrl;

    logic in_xfer;
    logic out_free;
    logic last_byte;

    // Captured input item.
    logic [WB_W-1:0]           wb_reg;
    logic signed [ACT_W-1:0]   act_low_reg;
    logic signed [ACT_W-1:0]   act_high_reg;
    logic [SCALE_W-1:0]        ws0_reg;
    logic [SCALE_W-1:0]        ws1_reg;
    logic [SCALE_W-1:0]        as0_reg;
    logic [SCALE_W-1:0]        as1_reg;
    logic signed [BIAS_W-1:0]  bias_reg;
    logic                      row_end_reg;

    // Running state.
    logic [POS_W-1:0]          pos_reg;
    logic signed [BSUM_W-1:0]  sum0_reg;
    logic signed [BSUM_W-1:0]  sum1_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic                      use_bias_reg;

    // Output register.
    logic                      m_valid_reg;
    logic signed [OUT_WIDTH-1:0] result_reg;
    logic signed [OUT_WIDTH-1:0] result_next;
    logic                      sat_reg;
    logic                      sat_next;

    logic signed [MUL_W-1:0]   prod_reg;
    logic signed [SCL_W-1:0]   scaled;
    logic signed [ADD_W-1:0]   acc_sum;
    logic signed [TOT_W-1:0]   total;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = ctrl.in_ready;
    assign out_free  = !m_valid_reg || m_tready;
    assign last_byte = (pos_reg == POS_W'(BLK_BYTES - 1));
    assign cfg_ready = 1'b1;

    i8dp_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_xfer   (in_xfer),
        .last_byte (last_byte),
        .row_end   (row_end_reg),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    i8dp_mul u_mul (
        .aclk          (aclk),
        .mul_sel       (ctrl.mul_sel),
        .mul_en        (ctrl.mul_en),
        .weight_byte   (wb_reg),
        .act_low       (act_low_reg),
        .act_high      (act_high_reg),
        .wscale_first  (ws0_reg),
        .wscale_second (ws1_reg),
        .ascale_first  (as0_reg),
        .ascale_second (as1_reg),
        .sum_first     (sum0_reg),
        .sum_second    (sum1_reg),
        .prod_reg      (prod_reg)
    );

    // Bring the scaled block sum to RES_FRAC fraction bits. When it carries
    // more fraction bits, it is rounded half up: add half, then floor.
    generate
        if (ALIGN_R > 0) begin : g_round
            logic signed [SCL_W-1:0] rounded;
            assign rounded = SCL_W'(prod_reg) + SCL_W'(1 << (ALIGN_R - 1));
            assign scaled  = rounded >>> ALIGN_R;
        end else begin : g_shift
            assign scaled = SCL_W'(prod_reg) <<< ALIGN_L;
        end
    endgenerate

    // Saturating accumulate of one scaled block.
    assign acc_sum = ADD_W'(acc_reg) + ADD_W'(scaled);

    always_comb begin
        if (acc_sum > ADD_W'(ACC_MAX)) begin
            acc_next = ACC_MAX;
        end else if (acc_sum < ADD_W'(ACC_MIN)) begin
            acc_next = ACC_MIN;
        end else begin
            acc_next = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // Row total with optional bias, clipped to the output width.
    assign total = TOT_W'(acc_reg) + (use_bias_reg ? TOT_W'(bias_reg) : TOT_W'(0));

    always_comb begin
        if (total > TOT_W'(OUT_MAX)) begin
            result_next = OUT_MAX;
            sat_next    = 1'b1;
        end else if (total < TOT_W'(OUT_MIN)) begin
            result_next = OUT_MIN;
            sat_next    = 1'b1;
        end else begin
            result_next = total[OUT_WIDTH-1:0];
            sat_next    = 1'b0;
        end
    end

    // Input capture; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            wb_reg       <= s_tdata[7:0];
            act_low_reg  <= s_tdata[15:8];
            act_high_reg <= s_tdata[23:16];
            ws0_reg      <= s_tdata[39:24];
            ws1_reg      <= s_tdata[55:40];
            as0_reg      <= s_tdata[71:56];
            as1_reg      <= s_tdata[87:72];
            bias_reg     <= s_tdata[119:88];
            row_end_reg  <= s_tlast;
        end
    end

    // Block sums, position and row accumulator. Block sums wrap at their
    // width. A row end discards any partial block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            sum0_reg <= '0;
            sum1_reg <= '0;
            acc_reg  <= '0;
        end else begin
            if (ctrl.sum0_add) begin
                sum0_reg <= sum0_reg + BSUM_W'(prod_reg);
            end
            if (ctrl.sum1_add) begin
                sum1_reg <= sum1_reg + BSUM_W'(prod_reg);
            end
            if (ctrl.pos_step) begin
                pos_reg <= last_byte ? '0 : pos_reg + POS_W'(1);
            end
            if (ctrl.acc_add) begin
                acc_reg <= acc_next;
            end
            if (ctrl.blk_done) begin
                sum0_reg <= '0;
                sum1_reg <= '0;
            end
            if (ctrl.row_done) begin
                pos_reg  <= '0;
                sum0_reg <= '0;
                sum1_reg <= '0;
                acc_reg  <= '0;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_bias_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            use_bias_reg <= cfg_data[0];
        end
    end

    // Output register: holds the result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.row_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.row_done) begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);
    assign m_tuser  = sat_reg;

endmodule

// File: rtl/i8dp_mul.sv
// ============================================================================
// i8dp_mul: shared multiplier
// Selects the operands for one product per cycle while mul_en is high and registers the result.
// The scale product is fed back for the block-sum scaling step.
// ============================================================================
module i8dp_mul (
    input  logic                                aclk,
    input  logic [i8dp_pkg::MSEL_W-1:0]         mul_sel,
    input  logic                                mul_en,
    input  logic [i8dp_pkg::WB_W-1:0]           weight_byte,
    input  logic signed [i8dp_pkg::ACT_W-1:0]   act_low,
    input  logic signed [i8dp_pkg::ACT_W-1:0]   act_high,
    input  logic [i8dp_pkg::SCALE_W-1:0]        wscale_first,
    input  logic [i8dp_pkg::SCALE_W-1:0]        wscale_second,
    input  logic [i8dp_pkg::SCALE_W-1:0]        ascale_first,
    input  logic [i8dp_pkg::SCALE_W-1:0]        ascale_second,
    input  logic signed [i8dp_pkg::BSUM_W-1:0]  sum_first,
    input  logic signed [i8dp_pkg::BSUM_W-1:0]  sum_second,
    output logic signed [i8dp_pkg::MUL_W-1:0]   prod_reg
);
    import i8dp_pkg::*;

    logic signed [NIB_W-1:0]   w_low;
    logic signed [NIB_W-1:0]   w_high;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [MUL_W-1:0]   prod_next;

    // A nibble minus eight is the nibble with its top bit inverted.
    assign w_low  = {~weight_byte[3], weight_byte[2:0]};
    assign w_high = {~weight_byte[7], weight_byte[6:4]};

    always_comb begin
        case (mul_sel)
            MSEL_BYTE0: begin
                op_a = MUL_A_W'(w_low);
                op_b = MUL_B_W'(act_low);
            end
            MSEL_BYTE1: begin
                op_a = MUL_A_W'(w_high);
                op_b = MUL_B_W'(act_high);
            end
            MSEL_SCL0: begin
                op_a = MUL_A_W'(wscale_first);
                op_b = MUL_B_W'(ascale_first);
            end
            MSEL_SCL1: begin
                op_a = MUL_A_W'(wscale_second);
                op_b = MUL_B_W'(ascale_second);
            end
            MSEL_SUM0: begin
                op_a = MUL_A_W'(sum_first);
                op_b = MUL_B_W'(prod_reg[SPROD_W-1:0]);
            end
            MSEL_SUM1: begin
                op_a = MUL_A_W'(sum_second);
                op_b = MUL_B_W'(prod_reg[SPROD_W-1:0]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// File: rtl/i8dp_seq.sv
// ============================================================================
// i8dp_seq: step sequencer
// Walks each accepted byte through the multiply-accumulate steps, the
// two block scalings at a block end and the result load at a row end.
// ============================================================================
module i8dp_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_xfer,
    input  logic                   last_byte,
    input  logic                   row_end,
    input  logic                   out_free,
    output i8dp_pkg::i8dp_ctrl_t   ctrl
);
    import i8dp_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_BYTE0 = 4'd1;
    localparam logic [ST_W-1:0] ST_BYTE1 = 4'd2;
    localparam logic [ST_W-1:0] ST_BYTE2 = 4'd3;
    localparam logic [ST_W-1:0] ST_SCL0  = 4'd4;
    localparam logic [ST_W-1:0] ST_ACC0  = 4'd5;
    localparam logic [ST_W-1:0] ST_SCL1  = 4'd6;
    localparam logic [ST_W-1:0] ST_ACC1  = 4'd7;
    localparam logic [ST_W-1:0] ST_FIN   = 4'd8;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                if (in_xfer) begin
                    state_next = ST_BYTE0;
                end
            end
            ST_BYTE0: begin
                ctrl.mul_sel = MSEL_BYTE0;
                ctrl.mul_en  = 1'b1;
                state_next   = ST_BYTE1;
            end
            ST_BYTE1: begin
                ctrl.mul_sel  = MSEL_BYTE1;
                ctrl.mul_en   = 1'b1;
                ctrl.sum0_add = 1'b1;
                state_next    = ST_BYTE2;
            end
            ST_BYTE2: begin
                ctrl.sum1_add = 1'b1;
                ctrl.pos_step = 1'b1;
                if (last_byte) begin
                    // Start the first scale product alongside the last add.
                    ctrl.mul_sel = MSEL_SCL0;
                    ctrl.mul_en  = 1'b1;
                    state_next   = ST_SCL0;
                end else if (row_end) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCL0: begin
                ctrl.mul_sel = MSEL_SUM0;
                ctrl.mul_en  = 1'b1;
                state_next   = ST_ACC0;
            end
            ST_ACC0: begin
                ctrl.acc_add = 1'b1;
                ctrl.mul_sel = MSEL_SCL1;
                ctrl.mul_en  = 1'b1;
                state_next   = ST_SCL1;
            end
            ST_SCL1: begin
                ctrl.mul_sel = MSEL_SUM1;
                ctrl.mul_en  = 1'b1;
                state_next   = ST_ACC1;
            end
            ST_ACC1: begin
                ctrl.acc_add  = 1'b1;
                ctrl.blk_done = 1'b1;
                state_next    = row_end ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (out_free) begin
                    ctrl.row_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/i8dp_check.sv
// ============================================================================
// i8dp_check: port-level checks for the block dot product
// Watches the top-level ports over time; attached by a bind statement.
// ============================================================================
module i8dp_check (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [i8dp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [0:0]                          m_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready
);
    import i8dp_pkg::*;

    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    // Every byte needs several multiplier steps, so a transfer is never
    // followed directly by another.
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A clipped result sits at one of the two limits.
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[OUT_WIDTH-1:0] == OUT_MAX) || (m_tdata[OUT_WIDTH-1:0] == OUT_MIN))
        else $error("saturated flag without a limit value");

    // A new result is loaded only from the row-end step, when input is held off.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the input side was idle");

endmodule

bind int4_int8_block_dot_product i8dp_check u_i8dp_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
